// ===== src/cspc_pkg.sv =====
`timescale 1ns / 1ps
package cspc_pkg;

	localparam int MaxDomesDef   = 64;
	localparam int AngleStepsDef = 16;
	localparam int TabLen        = 24;

	localparam logic [14:0] FullTurn    = 15'd23040;
	localparam logic [14:0] HalfTurn    = 15'd11520;
	localparam logic [14:0] QuarterTurn = 15'd5760;

	localparam logic [1:0] CfgDomeCount = 2'd0;
	localparam logic [1:0] CfgResScale  = 2'd1;
	localparam logic [1:0] CfgNullValue = 2'd2;

	localparam logic ReqLoad  = 1'b0;
	localparam logic ReqPixel = 1'b1;

	// arctangent of 2^-i in 1/16384 degree
	function automatic logic [19:0] atan_entry(input logic [4:0] i);
		logic [19:0] r;
		begin
			case (i)
				5'd0:  r = 20'd737280;
				5'd1:  r = 20'd435242;
				5'd2:  r = 20'd229970;
				5'd3:  r = 20'd116736;
				5'd4:  r = 20'd58595;
				5'd5:  r = 20'd29326;
				5'd6:  r = 20'd14667;
				5'd7:  r = 20'd7334;
				5'd8:  r = 20'd3667;
				5'd9:  r = 20'd1833;
				5'd10: r = 20'd917;
				5'd11: r = 20'd458;
				5'd12: r = 20'd229;
				5'd13: r = 20'd115;
				5'd14: r = 20'd57;
				5'd15: r = 20'd29;
				5'd16: r = 20'd14;
				5'd17: r = 20'd7;
				5'd18: r = 20'd4;
				5'd19: r = 20'd2;
				5'd20: r = 20'd1;
				default: r = 20'd0;
			endcase
			return r;
		end
	endfunction

	typedef struct packed {
		logic        start;
		logic [27:0] east;
		logic [27:0] north;
	} cspc_az_req_t;

	typedef struct packed {
		logic        done;
		logic [14:0] az;
	} cspc_az_rsp_t;

endpackage

// ===== src/cspc_cordic.sv =====
`timescale 1ns / 1ps
// iterative vectoring cordic, one rotation per cycle
module cspc_cordic import cspc_pkg::*; #(
	parameter int AngleSteps = AngleStepsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cspc_az_req_t req,
	output cspc_az_rsp_t rsp
);

	localparam int StepW = $clog2(AngleSteps + 1);

	logic             busy_q;
	logic [StepW-1:0] step_q;
	logic signed [31:0] x_q, y_q;
	logic signed [24:0] z_q;
	logic             east_neg_q, north_neg_q, zero_q;
	logic             done_q;
	logic [14:0]      az_q;

	logic signed [31:0] xs, ys, nx, ny;
	logic signed [24:0] nz;
	logic [4:0]         idx;
	logic signed [24:0] zr;
	logic [14:0]        th, az_c;
	logic signed [27:0] e_s, n_s;

	assign idx = 5'(step_q);
	assign xs  = x_q >>> idx;
	assign ys  = y_q >>> idx;
	assign e_s = req.east;
	assign n_s = req.north;

	// one micro-rotation
	always_comb begin
		nx = x_q;
		ny = y_q;
		nz = z_q;
		if (y_q > 0) begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + 25'($signed({1'b0, atan_entry(idx)}));
		end else if (y_q < 0) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - 25'($signed({1'b0, atan_entry(idx)}));
		end
	end

	// quadrant placement
	always_comb begin
		zr = (z_q + 25'sd128) >>> 8;
		if (z_q < 0) th = '0;
		else if (zr > 25'sd5760) th = QuarterTurn;
		else th = zr[14:0];
		if (!east_neg_q) az_c = north_neg_q ? HalfTurn - th : th;
		else az_c = north_neg_q ? HalfTurn + th : FullTurn - th;
		if (az_c >= FullTurn) az_c = az_c - FullTurn;
		if (zero_q) az_c = HalfTurn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == StepW'(AngleSteps)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q         <= n_s[27] ? 32'(-n_s) : 32'(n_s);
			y_q         <= e_s[27] ? 32'(-e_s) : 32'(e_s);
			z_q         <= '0;
			east_neg_q  <= e_s[27];
			north_neg_q <= n_s[27];
			zero_q      <= (e_s == 0) && (n_s == 0);
		end else if (busy_q && step_q != StepW'(AngleSteps)) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end else if (busy_q) begin
			az_q <= az_c;
		end
	end

	assign rsp.done = done_q;
	assign rsp.az   = az_q;

endmodule

// ===== src/circular_sector_pixel_classifier.sv =====
`timescale 1ns / 1ps
// Circular sector pixel classifier.
// s_axis words carry either a dome load (tuser req_type 0) or a pixel (req_type 1).
// A load writes one table slot in its accepting cycle and gives no result, so
// loads can follow back to back.
// A pixel walks domes 0..min(dome_count,MaxDomes)-1 one at a time through table read,
// scale/diff, squares, sum/compare and advance, and when the dome is a sector and the
// point lies inside, the shared cordic unit runs between compare and advance.
// The next item is taken in the cycle the result first shows on m_axis.
// One result word (pixel_class, covered) per pixel sits in an output register;
// a stalled receiver lets the next pixel finish, then holds the block with
// s_axis_tready low until the register drains.
// cfg writes (index 0 dome_count, 1 res_scale, 2 null_value) are always taken
// and belong between items.
// Reset gives dome_count 0, res_scale 1, null_value 0 and an empty output
// register; the dome table holds no reset value and must be loaded before use.
module circular_sector_pixel_classifier import cspc_pkg::*; #(
	parameter int MaxDomes   = MaxDomesDef,
	parameter int AngleSteps = AngleStepsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// dome_index, center_x, center_y, radius_sq, start_az, end_az, dome_class,
	// pixel_x, pixel_y
	input  logic [175:0] s_axis_tdata,
	// req_type
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pixel_class, covered, zero fill
	output logic [15:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	localparam int IdxW = (MaxDomes > 1) ? $clog2(MaxDomes) : 1;
	localparam int CntW = $clog2(MaxDomes + 1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_READ  = 8'b0000_0010,
		ST_DIFF  = 8'b0000_0100,
		ST_SQR   = 8'b0000_1000,
		ST_CMP   = 8'b0001_0000,
		ST_AZ    = 8'b0010_0000,
		ST_NEXT  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	// field split
	logic [5:0]         in_idx;
	logic [25:0]        in_cx, in_cy;
	logic [47:0]        in_r2;
	logic [14:0]        in_sa, in_ea;
	logic [7:0]         in_cls;
	logic [15:0]        in_px, in_py;
	assign in_idx = s_axis_tdata[5:0];
	assign in_cx  = s_axis_tdata[31:6];
	assign in_cy  = s_axis_tdata[57:32];
	assign in_r2  = s_axis_tdata[105:58];
	assign in_sa  = s_axis_tdata[120:106];
	assign in_ea  = s_axis_tdata[135:121];
	assign in_cls = s_axis_tdata[143:136];
	assign in_px  = s_axis_tdata[159:144];
	assign in_py  = s_axis_tdata[175:160];

	// config registers
	logic [6:0] dome_count_q;
	logic [5:0] res_scale_q;
	logic [7:0] null_value_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dome_count_q <= '0;
			res_scale_q  <= 6'd1;
			null_value_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgDomeCount: dome_count_q <= cfg_data[6:0];
				CfgResScale:  res_scale_q  <= cfg_data[5:0];
				CfgNullValue: null_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// dome table memory
	logic [137:0] mem [MaxDomes];
	logic [137:0] rd_s1;
	logic [IdxW-1:0] k_q;
	logic             s_acc;
	logic             ld_ok;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign ld_ok = s_acc && s_axis_tuser == ReqLoad && 32'(in_idx) < MaxDomes;

	always_ff @(posedge clk) begin
		if (ld_ok)
			mem[IdxW'(in_idx)] <= {in_cls, (in_ea == FullTurn) ? 15'd0 : in_ea, in_sa,
				in_r2, in_cy, in_cx};
		rd_s1 <= mem[k_q];
	end

	// datapath registers
	logic [CntW-1:0] n_q;
	logic [15:0]     px_q, py_q;
	logic signed [27:0] dx_q, dy_q;
	logic [55:0]     sqx_q, sqy_q;
	logic [7:0]      cls_q;
	logic            hit_q;
	logic [14:0]     sa_q, ea_q;
	logic [47:0]     r2_q;
	logic [7:0]      dcls_q;
	logic [21:0]     sx, sy;
	logic [56:0]     d2;

	assign sx = px_q * res_scale_q;
	assign sy = py_q * res_scale_q;
	assign d2 = {1'b0, sqx_q} + {1'b0, sqy_q};

	cspc_az_req_t az_req;
	cspc_az_rsp_t az_rsp;
	assign az_req.start = (state_q == ST_CMP) && (d2 <= {9'd0, r2_q}) && (sa_q != ea_q);
	assign az_req.east  = dx_q;
	assign az_req.north = -dy_q;

	cspc_cordic #(.AngleSteps(AngleSteps)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(az_req), .rsp(az_rsp)
	);

	logic az_match;
	always_comb begin
		if (sa_q < ea_q) az_match = az_rsp.az >= sa_q && az_rsp.az <= ea_q;
		else az_match = az_rsp.az >= sa_q || az_rsp.az <= ea_q;
	end

	// result moves out once the output register is free or draining
	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic        out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	assign s_axis_tready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_acc && s_axis_tuser == ReqPixel) begin
					k_q   <= '0;
					hit_q <= 1'b0;
					state_q <= (dome_count_q == 0) ? ST_OUT : ST_READ;
				end
				ST_READ: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQR;
				ST_SQR:  state_q <= ST_CMP;
				ST_CMP: begin
					if (d2 <= {9'd0, r2_q}) begin
						if (sa_q == ea_q) begin
							hit_q <= 1'b1;
							state_q <= ST_NEXT;
						end else state_q <= ST_AZ;
					end else state_q <= ST_NEXT;
				end
				ST_AZ: if (az_rsp.done) begin
					if (az_match) hit_q <= 1'b1;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (CntW'(k_q) + 1'b1 >= n_q) state_q <= ST_OUT;
					else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_OUT: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_acc) begin
			px_q  <= in_px;
			py_q  <= in_py;
			cls_q <= null_value_q;
			n_q   <= (32'(dome_count_q) > MaxDomes) ? CntW'(MaxDomes) : CntW'(dome_count_q);
		end
		if (state_q == ST_DIFF) begin
			dx_q   <= $signed({2'b0, sx, 4'b0}) - 28'($signed(rd_s1[25:0]));
			dy_q   <= $signed({2'b0, sy, 4'b0}) - 28'($signed(rd_s1[51:26]));
			r2_q   <= rd_s1[99:52];
			sa_q   <= rd_s1[114:100];
			ea_q   <= rd_s1[129:115];
			dcls_q <= rd_s1[137:130];
		end
		if (state_q == ST_SQR) begin
			sqx_q <= 56'(dx_q * dx_q);
			sqy_q <= 56'(dy_q * dy_q);
		end
		if (state_q == ST_CMP && d2 <= {9'd0, r2_q} && sa_q == ea_q) cls_q <= dcls_q;
		if (state_q == ST_AZ && az_rsp.done && az_match) cls_q <= dcls_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_data_q  <= {7'd0, hit_q, cls_q};
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_uncovered_null: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == null_value_q)
		else $error("null class");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import cspc_pkg::*;

	typedef struct {
		logic               kind;
		logic [5:0]         slot;
		logic signed [25:0] cx;
		logic signed [25:0] cy;
		logic [47:0]        rsq;
		logic [14:0]        saz;
		logic [14:0]        eaz;
		logic [7:0]         cls;
		logic [15:0]        pxl;
		logic [15:0]        pyl;
	} dome_req_t;

	typedef struct {
		logic [7:0] cls;
		logic       cov;
	} class_word_t;

	typedef struct {
		dome_req_t  r;
		bit         typed;
		logic [7:0] cls;
		logic       cov;
	} stim_row_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_valid = 0;
	logic         s_ready;
	logic [175:0] s_data = '0;
	logic         s_user = 0;
	logic         m_valid;
	logic         m_ready = 0;
	logic [15:0]  m_data;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = CfgDomeCount;
	logic [7:0]   cfg_data = '0;

	// shadow of the dome table and registers
	logic signed [25:0] dome_cx [MaxDomesDef];
	logic signed [25:0] dome_cy [MaxDomesDef];
	logic [47:0]        dome_rsq [MaxDomesDef];
	logic [14:0]        dome_saz [MaxDomesDef];
	logic [14:0]        dome_eaz [MaxDomesDef];
	logic [7:0]         dome_cls [MaxDomesDef];
	logic [6:0]         dome_count = 0;
	logic [5:0]         res_scale = 1;
	logic [7:0]         null_value = 0;

	longint atan_lut [TabLen] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};

	class_word_t pixel_class_q [$];
	stim_row_t   stim_rows [$];
	int          mismatch_cnt = 0;
	int          snd_idle_pct = 0;
	int          rcv_stall_pct = 0;

	circular_sector_pixel_classifier u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
		.s_axis_tdata(s_data), .s_axis_tuser(s_user),
		.m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#50ms;
		$display("simulation failed");
		$finish;
	end

	// azimuth clockwise from up, 1/64 degree, via vectoring cordic
	function automatic int sector_azimuth(longint east, longint north);
		longint x, y, z, nx, th;
		int a;
		if (east == 0 && north == 0)
			return int'(HalfTurn);
		x = north < 0 ? -north : north;
		y = east < 0 ? -east : east;
		z = 0;
		for (int i = 0; i < AngleStepsDef && i < TabLen; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				x = nx;
				z += atan_lut[i];
			end else if (y < 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				x = nx;
				z -= atan_lut[i];
			end
		end
		th = z < 0 ? 0 : (z + 128) >>> 8;
		if (th > longint'(QuarterTurn))
			th = longint'(QuarterTurn);
		if (east >= 0)
			a = north >= 0 ? int'(th) : int'(HalfTurn) - int'(th);
		else
			a = north < 0 ? int'(HalfTurn) + int'(th) : int'(FullTurn) - int'(th);
		if (a >= int'(FullTurn))
			a -= int'(FullTurn);
		return a;
	endfunction

	// class of the last dome covering the pixel
	function automatic class_word_t classify_pixel(logic [15:0] pxl, logic [15:0] pyl);
		class_word_t w;
		longint px, py, dx, dy;
		longint unsigned d2;
		int n, az;
		bit hit;
		w.cls = null_value;
		w.cov = 0;
		px = longint'(pxl) * longint'(res_scale) * 16;
		py = longint'(pyl) * longint'(res_scale) * 16;
		n = dome_count > MaxDomesDef ? MaxDomesDef : int'(dome_count);
		for (int k = 0; k < n; k++) begin
			dx = px - longint'(dome_cx[k]);
			dy = py - longint'(dome_cy[k]);
			d2 = longint'(dx * dx) + longint'(dy * dy);
			if (d2 > {16'd0, dome_rsq[k]})
				continue;
			if (dome_saz[k] == dome_eaz[k]) begin
				hit = 1;
			end else begin
				az = sector_azimuth(dx, -dy);
				if (dome_saz[k] < dome_eaz[k])
					hit = az >= int'(dome_saz[k]) && az <= int'(dome_eaz[k]);
				else
					hit = az >= int'(dome_saz[k]) || az <= int'(dome_eaz[k]);
			end
			if (hit) begin
				w.cls = dome_cls[k];
				w.cov = 1;
			end
		end
		return w;
	endfunction

	// apply an accepted word to the shadow state
	function automatic void absorb_word(dome_req_t r);
		if (r.kind == ReqLoad) begin
			dome_cx[r.slot] = r.cx;
			dome_cy[r.slot] = r.cy;
			dome_rsq[r.slot] = r.rsq;
			dome_saz[r.slot] = r.saz;
			dome_eaz[r.slot] = r.eaz == FullTurn ? 15'd0 : r.eaz;
			dome_cls[r.slot] = r.cls;
		end else begin
			pixel_class_q.insert(pixel_class_q.size(), classify_pixel(r.pxl, r.pyl));
		end
	endfunction

	function automatic dome_req_t load_word(int slot, int cx, int cy, longint rsq,
			int saz, int eaz, int cls);
		dome_req_t r;
		r = '{default: '0};
		r.kind = ReqLoad;
		r.slot = 6'(slot);
		r.cx = 26'(cx);
		r.cy = 26'(cy);
		r.rsq = 48'(rsq);
		r.saz = 15'(saz);
		r.eaz = 15'(eaz);
		r.cls = 8'(cls);
		return r;
	endfunction

	function automatic dome_req_t pixel_word(int x, int y);
		dome_req_t r;
		r = '{default: '0};
		r.kind = ReqPixel;
		r.pxl = 16'(x);
		r.pyl = 16'(y);
		return r;
	endfunction

	// add one row to the directed table
	function automatic void add_row(dome_req_t r, bit typed, logic [7:0] cls, logic cov);
		stim_row_t row;
		row.r = r;
		row.typed = typed;
		row.cls = cls;
		row.cov = cov;
		stim_rows.insert(stim_rows.size(), row);
	endfunction

	function automatic int pick_az();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return int'(QuarterTurn);
			2: return int'(HalfTurn);
			3: return int'(FullTurn);
			4: return int'($urandom_range(23041, 32767));
			default: return int'($urandom_range(0, 23039));
		endcase
	endfunction

	function automatic dome_req_t random_dome();
		dome_req_t r;
		int rad, s;
		r = load_word(int'($urandom_range(0, 63)), 0, 0, 0, 0, 0,
			int'($urandom_range(0, 255)));
		if ($urandom_range(0, 4) == 0) begin
			r.cx = 26'($urandom);
			r.cy = 26'($urandom);
			r.rsq = 48'({$urandom, $urandom});
			r.saz = 15'($urandom);
			r.eaz = 15'($urandom);
		end else begin
			rad = int'($urandom_range(0, 2000));
			r.cx = 26'(int'($urandom_range(0, 88000)) - 8000);
			r.cy = 26'(int'($urandom_range(0, 88000)) - 8000);
			r.rsq = 48'(longint'(rad) * rad * 256 + longint'($urandom_range(0, 255)));
			s = pick_az();
			r.saz = 15'(s);
			r.eaz = $urandom_range(0, 4) == 0 ? 15'(s) : 15'(pick_az());
		end
		return r;
	endfunction

	function automatic dome_req_t random_pixel();
		int lim;
		if ($urandom_range(0, 9) == 0)
			return pixel_word(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
		lim = res_scale == 0 ? 65535 : 5000 / int'(res_scale);
		return pixel_word(int'($urandom_range(0, lim)), int'($urandom_range(0, lim)));
	endfunction

	// push one word, with optional idle gap first
	task automatic send_word(dome_req_t r);
		if (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct) begin
			s_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_data <= {r.pyl, r.pxl, r.cls, r.eaz, r.saz, r.rsq, r.cy, r.cx, r.slot};
		s_user <= r.kind;
		s_valid <= 1;
		do @(posedge clk); while (!s_ready);
		absorb_word(r);
	endtask

	// walk the directed table, typed rows replace the predicted word
	task automatic run_rows();
		foreach (stim_rows[i]) begin
			send_word(stim_rows[i].r);
			if (stim_rows[i].typed)
				pixel_class_q[pixel_class_q.size() - 1] = '{stim_rows[i].cls,
					stim_rows[i].cov};
		end
		stim_rows.delete();
	endtask

	// register write once all results are back and the block has settled
	task automatic write_reg(logic [1:0] idx, logic [7:0] v);
		s_valid <= 0;
		while (pixel_class_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CfgDomeCount: dome_count = v[6:0];
			CfgResScale:  res_scale = v[5:0];
			CfgNullValue: null_value = v;
			default: ;
		endcase
	endtask

	// receiver stall and result check
	always @(posedge clk) begin
		class_word_t w;
		m_ready <= $urandom_range(0, 99) >= rcv_stall_pct;
		if (arst_n && m_valid && m_ready) begin
			if (pixel_class_q.size() == 0) begin
				$error("result word with no expectation: %h", m_data);
				mismatch_cnt++;
			end else begin
				w = pixel_class_q.pop_front();
				if (m_data[7:0] !== w.cls) begin
					$error("pixel_class expected %0d actual %0d", w.cls, m_data[7:0]);
					mismatch_cnt++;
				end
				if (m_data[8] !== w.cov) begin
					$error("covered expected %0d actual %0d", w.cov, m_data[8]);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		dome_req_t fill_r;
		int cnt_tab [8] = '{64, 127, 1, 0, 33, 64, 10, 20};
		int res_tab [8] = '{1, 63, 32, 0, 1, 2, 5, 3};
		int nul_tab [8] = '{255, 0, 170, 85, 1, 254, 16, 7};
		int mode;

		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset config: no domes, null class 0
		add_row(pixel_word(0, 0), 1, 8'd0, 1'b0);
		run_rows();
		write_reg(CfgDomeCount, 8'd6);
		write_reg(CfgNullValue, 8'h33);

		// directed table: full circle, extremes, sectors, wrap, centre point
		add_row(load_word(0, 0, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 1), 0, 0, 0);
		add_row(load_word(1, 33554431, -33554432, 0, int'(FullTurn), int'(FullTurn), 2),
			0, 0, 0);
		add_row(load_word(2, 1600, 1600, 640000, 0, int'(QuarterTurn), 3), 0, 0, 0);
		add_row(load_word(3, 1600, 1600, 640000, 17280, int'(QuarterTurn), 4), 0, 0, 0);
		add_row(load_word(4, 1600, 1600, 640000, 30000, 24000, 5), 0, 0, 0);
		add_row(load_word(5, 3200, 3200, 0, 11000, 12000, 255), 0, 0, 0);
		add_row(pixel_word(0, 0), 1, 8'd1, 1'b1);
		add_row(pixel_word(65535, 65535), 0, 0, 0);
		add_row(pixel_word(120, 90), 0, 0, 0);
		add_row(pixel_word(80, 90), 0, 0, 0);
		add_row(pixel_word(100, 100), 0, 0, 0);
		add_row(pixel_word(200, 200), 0, 0, 0);
		add_row(pixel_word(100, 130), 0, 0, 0);
		add_row(pixel_word(70, 100), 0, 0, 0);
		add_row(pixel_word(65535, 0), 0, 0, 0);
		add_row(pixel_word(0, 65535), 0, 0, 0);
		run_rows();

		// fill every slot so any dome count reads written entries only
		for (int k = 0; k < MaxDomesDef; k++) begin
			fill_r = random_dome();
			fill_r.slot = 6'(k);
			send_word(fill_r);
		end

		// random phases over settings and idle patterns
		for (int p = 0; p < 8; p++) begin
			snd_idle_pct = 0;
			rcv_stall_pct = 0;
			write_reg(CfgDomeCount, 8'(cnt_tab[p]));
			write_reg(CfgResScale, 8'(res_tab[p]));
			write_reg(CfgNullValue, 8'(nul_tab[p]));
			mode = p % 4;
			snd_idle_pct = mode == 1 ? 55 : (mode == 3 ? 11 : 0);
			rcv_stall_pct = mode == 2 ? 55 : (mode == 3 ? 11 : 0);
			for (int n = 0; n < 55; n++) begin
				if (p == 2 && n == 30) begin
					s_valid <= 0;
					do @(posedge clk); while (pixel_class_q.size() != 0);
				end
				send_word($urandom_range(0, 3) == 0 ? random_dome() : random_pixel());
			end
		end

		s_valid <= 0;
		while (pixel_class_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cspc_pkg.sv
src/cspc_cordic.sv
src/circular_sector_pixel_classifier.sv
dv/testbench.sv
